FILE: rtl/hpp_pkg.sv
// Shared types, codes and byte-class helpers for the HTTP request header parser.
// Used by hpp_step and http_request_header_parser; depends on nothing.
package hpp_pkg;

	// parser states, one-hot
	typedef enum logic [19:0] {
		PS_METHOD_START = 20'h00001,
		PS_METHOD       = 20'h00002,
		PS_URI          = 20'h00004,
		PS_VER_H        = 20'h00008,
		PS_VER_T1       = 20'h00010,
		PS_VER_T2       = 20'h00020,
		PS_VER_P        = 20'h00040,
		PS_VER_SLASH    = 20'h00080,
		PS_MAJOR_START  = 20'h00100,
		PS_MAJOR        = 20'h00200,
		PS_MINOR_START  = 20'h00400,
		PS_MINOR        = 20'h00800,
		PS_NL1          = 20'h01000,
		PS_LINE_START   = 20'h02000,
		PS_LWS          = 20'h04000,
		PS_NAME         = 20'h08000,
		PS_SPACE_VALUE  = 20'h10000,
		PS_VALUE        = 20'h20000,
		PS_NL2          = 20'h40000,
		PS_NL3          = 20'h80000
	} pstate_t;

	typedef enum logic [1:0] {
		STS_MORE = 2'd0,
		STS_GOOD = 2'd1,
		STS_BAD  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CLS_NONE   = 3'd0,
		CLS_METHOD = 3'd1,
		CLS_URI    = 3'd2,
		CLS_NAME   = 3'd3,
		CLS_VALUE  = 3'd4
	} byte_class_t;

	typedef enum logic [1:0] {
		MTH_NONE = 2'd0,
		MTH_GET  = 2'd1,
		MTH_POST = 2'd2,
		MTH_HEAD = 2'd3
	} method_t;

	localparam logic OP_BYTE    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// candidate bit positions in the method match vector
	localparam int unsigned MB_GET  = 0;
	localparam int unsigned MB_POST = 1;
	localparam int unsigned MB_HEAD = 2;

	localparam logic [2:0] MLEN_MAX = 3'd7;

	typedef struct packed {
		pstate_t    pstate;
		logic [2:0] mlen;
		logic [2:0] mmatch;
		method_t    method;
		logic       hdr_seen;
		logic [7:0] major;
		logic [7:0] minor;
	} ctx_t;

	localparam ctx_t CTX_RESET = '{
		pstate:   PS_METHOD_START,
		mlen:     3'd0,
		mmatch:   3'b111,
		method:   MTH_NONE,
		hdr_seen: 1'b0,
		major:    8'd0,
		minor:    8'd0
	};

	typedef struct packed {
		status_t     status;
		byte_class_t byte_class;
		logic [7:0]  data_out;
		logic        new_header;
		method_t     method_code;
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
	} result_t;

	function automatic logic is_ctl(input logic [7:0] c);
		return (c <= 8'd31) || (c == 8'd127);
	endfunction

	function automatic logic is_sep(input logic [7:0] c);
		logic r;
		case (c) inside
			"(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
			"[", "]", "?", "=", "{", "}", " ", 8'h09: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// bytes 128..255 are neither characters nor controls
	function automatic logic is_token(input logic [7:0] c);
		return !c[7] && !is_ctl(c) && !is_sep(c);
	endfunction

	function automatic logic is_numeral(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	// v*10 + digit, clamped at 255
	function automatic logic [7:0] sat_digit(input logic [7:0] v, input logic [7:0] c);
		logic [11:0] n;
		n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {8'd0, c[3:0]};
		return (n > 12'd255) ? 8'hFF : n[7:0];
	endfunction

	// which candidates accept lower-case char lc at position p
	function automatic logic [2:0] method_hits(input logic [2:0] p, input logic [7:0] lc);
		logic [2:0] h;
		h = 3'b000;
		case (p)
			3'd0: begin
				h[MB_GET]  = (lc == "g");
				h[MB_POST] = (lc == "p");
				h[MB_HEAD] = (lc == "h");
			end
			3'd1: begin
				h[MB_GET]  = (lc == "e");
				h[MB_POST] = (lc == "o");
				h[MB_HEAD] = (lc == "e");
			end
			3'd2: begin
				h[MB_GET]  = (lc == "t");
				h[MB_POST] = (lc == "s");
				h[MB_HEAD] = (lc == "a");
			end
			3'd3: begin
				h[MB_POST] = (lc == "t");
				h[MB_HEAD] = (lc == "d");
			end
			default: h = 3'b000;
		endcase
		return h;
	endfunction

endpackage

FILE: rtl/hpp_step.sv
// Combinational next-state and result logic of the request parser for one byte.
// Depends on hpp_pkg.
module hpp_step import hpp_pkg::*; (
	input  ctx_t       cur,
	input  logic       op,
	input  logic [7:0] data_byte,
	output ctx_t       nxt,
	output result_t    res
);

	always_comb begin
		logic        bad;
		logic        good;
		logic [7:0]  c;
		logic [7:0]  lc;
		byte_class_t cls;
		logic [7:0]  dout;
		logic        newh;
		method_t     code;

		c    = data_byte;
		lc   = ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
		bad  = 1'b0;
		good = 1'b0;
		cls  = CLS_NONE;
		dout = 8'd0;
		newh = 1'b0;
		code = MTH_NONE;
		nxt  = cur;

		if (op == OP_RESTART) begin
			nxt = CTX_RESET;
		end else begin
			unique case (cur.pstate)
				PS_METHOD_START, PS_METHOD: begin
					if (cur.pstate == PS_METHOD && c == " ") begin
						if (cur.mmatch[MB_GET] && cur.mlen == 3'd3)
							code = MTH_GET;
						else if (cur.mmatch[MB_POST] && cur.mlen == 3'd4)
							code = MTH_POST;
						else if (cur.mmatch[MB_HEAD] && cur.mlen == 3'd4)
							code = MTH_HEAD;
						if (code != MTH_NONE) begin
							nxt.method = code;
							nxt.pstate = PS_URI;
						end else begin
							bad = 1'b1;
						end
					end else if (!is_token(c)) begin
						bad = 1'b1;
					end else begin
						nxt.mmatch = cur.mmatch & method_hits(cur.mlen, lc);
						if (cur.mlen != MLEN_MAX)
							nxt.mlen = cur.mlen + 3'd1;
						nxt.pstate = PS_METHOD;
						cls  = CLS_METHOD;
						dout = lc;
					end
				end
				PS_URI: begin
					if (c == " ") nxt.pstate = PS_VER_H;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						cls  = CLS_URI;
						dout = c;
					end
				end
				PS_VER_H: begin
					if (c == "H") nxt.pstate = PS_VER_T1; else bad = 1'b1;
				end
				PS_VER_T1: begin
					if (c == "T") nxt.pstate = PS_VER_T2; else bad = 1'b1;
				end
				PS_VER_T2: begin
					if (c == "T") nxt.pstate = PS_VER_P; else bad = 1'b1;
				end
				PS_VER_P: begin
					if (c == "P") nxt.pstate = PS_VER_SLASH; else bad = 1'b1;
				end
				PS_VER_SLASH: begin
					if (c == "/") begin
						nxt.major  = 8'd0;
						nxt.minor  = 8'd0;
						nxt.pstate = PS_MAJOR_START;
					end else begin
						bad = 1'b1;
					end
				end
				PS_MAJOR_START: begin
					if (is_numeral(c)) begin
						nxt.major  = sat_digit(cur.major, c);
						nxt.pstate = PS_MAJOR;
					end else begin
						bad = 1'b1;
					end
				end
				PS_MAJOR: begin
					if (c == ".") nxt.pstate = PS_MINOR_START;
					else if (is_numeral(c)) nxt.major = sat_digit(cur.major, c);
					else bad = 1'b1;
				end
				PS_MINOR_START: begin
					if (is_numeral(c)) begin
						nxt.minor  = sat_digit(cur.minor, c);
						nxt.pstate = PS_MINOR;
					end else begin
						bad = 1'b1;
					end
				end
				PS_MINOR: begin
					if (c == 8'h0D) nxt.pstate = PS_NL1;
					else if (is_numeral(c)) nxt.minor = sat_digit(cur.minor, c);
					else bad = 1'b1;
				end
				PS_NL1, PS_NL2: begin
					if (c == 8'h0A) nxt.pstate = PS_LINE_START; else bad = 1'b1;
				end
				PS_LINE_START: begin
					if (c == 8'h0D) nxt.pstate = PS_NL3;
					else if (cur.hdr_seen && (c == " " || c == 8'h09))
						nxt.pstate = PS_LWS;
					else if (!is_token(c)) bad = 1'b1;
					else begin
						nxt.hdr_seen = 1'b1;
						nxt.pstate   = PS_NAME;
						cls  = CLS_NAME;
						dout = c;
						newh = 1'b1;
					end
				end
				PS_LWS: begin
					if (c == 8'h0D) nxt.pstate = PS_NL2;
					else if (c == " " || c == 8'h09) nxt.pstate = PS_LWS;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						nxt.pstate = PS_VALUE;
						cls  = CLS_VALUE;
						dout = c;
					end
				end
				PS_NAME: begin
					if (c == ":") nxt.pstate = PS_SPACE_VALUE;
					else if (!is_token(c)) bad = 1'b1;
					else begin
						cls  = CLS_NAME;
						dout = c;
					end
				end
				PS_SPACE_VALUE: begin
					if (c == " ") nxt.pstate = PS_VALUE; else bad = 1'b1;
				end
				PS_VALUE: begin
					if (c == 8'h0D) nxt.pstate = PS_NL2;
					else if (is_ctl(c)) bad = 1'b1;
					else begin
						cls  = CLS_VALUE;
						dout = c;
					end
				end
				PS_NL3: begin
					if (c == 8'h0A) good = 1'b1; else bad = 1'b1;
				end
				default: bad = 1'b1;
			endcase
		end

		// a rejected byte leaves every piece of state alone
		if (bad) begin
			nxt  = cur;
			cls  = CLS_NONE;
			dout = 8'd0;
			newh = 1'b0;
		end

		res.status        = bad ? STS_BAD : (good ? STS_GOOD : STS_MORE);
		res.byte_class    = cls;
		res.data_out      = dout;
		res.new_header    = newh;
		res.method_code   = nxt.method;
		res.version_major = nxt.major;
		res.version_minor = nxt.minor;
	end

endmodule

FILE: rtl/http_request_header_parser.sv
// Top level of the HTTP request header parser: context register, output register
// and skid word around hpp_step. Depends on hpp_pkg and hpp_step.
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid, in_stall | op, data_byte
//  out     | out_valid,out_stall| status, byte_class, data_out, new_header,
//          |                    | method_code, version_major, version_minor
//
// One word per cycle while in_stall is low, one result word per input word.
// The parse context updates in the same cycle that a word is accepted; the
// result lands in the output register, or in the skid word when the output is
// stalled. in_stall is the registered skid-full flag.
// arst_n clears the context, the output valid and the skid valid.
module http_request_header_parser import hpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] data_byte,

	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] status,
	output logic [2:0] byte_class,
	output logic [7:0] data_out,
	output logic       new_header,
	output logic [1:0] method_code,
	output logic [7:0] version_major,
	output logic [7:0] version_minor
);

	ctx_t    ctx_q;
	ctx_t    ctx_nxt;
	result_t res_nxt;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    acc;
	logic    take;

	// accept whenever the skid word is free; output drains when not stalled
	assign in_stall = skid_valid_q;
	assign acc      = in_valid && !skid_valid_q;
	assign take     = out_valid_q && !out_stall;

	hpp_step u_step (
		.cur       (ctx_q),
		.op        (op),
		.data_byte (data_byte),
		.nxt       (ctx_nxt),
		.res       (res_nxt)
	);

	// parse context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RESET;
		end else if (acc) begin
			ctx_q <= ctx_nxt;
		end
	end

	// output register and skid word: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (acc) begin
			if (out_valid_q && !take) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register and skid word: payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) out_q <= skid_q;
		end else if (acc) begin
			if (out_valid_q && !take) skid_q <= res_nxt;
			else out_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign byte_class    = out_q.byte_class;
	assign data_out      = out_q.data_out;
	assign new_header    = out_q.new_header;
	assign method_code   = out_q.method_code;
	assign version_major = out_q.version_major;
	assign version_minor = out_q.version_minor;

	// skid word only fills behind a held output word
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid word valid without output word");

	// restart returns the context to its reset value
	a_restart_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op == OP_RESTART) |=> (ctx_q == CTX_RESET))
		else $error("context not reset after restart");

	// a rejected byte leaves the context untouched
	a_bad_keeps_ctx: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && res_nxt.status == STS_BAD) |=> (ctx_q == $past(ctx_q)))
		else $error("context changed on bad byte");

	// a bad result carries no byte
	a_bad_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STS_BAD) |->
			(out_q.byte_class == CLS_NONE && out_q.data_out == 8'd0 && !out_q.new_header))
		else $error("bad result carries byte data");

endmodule
